FILE: src/mgsf_pkg.sv
// Shared types, constants and helper functions for the mask grow/shrink/feather block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mgsf_pkg;

    // default frame store geometry and op slots
    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;
    localparam int unsigned DEF_MAX_OPS    = 8;

    // field and register widths
    localparam int DIM_W   = 9;
    localparam int PROG_W  = 20;
    localparam int PASS_W  = 8;
    localparam int LEVEL_W = 16;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int RSEL_W  = ADDR_W - 2;

    // register map (word index)
    localparam logic [RSEL_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [RSEL_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [RSEL_W-1:0] REG_STAGE_ONE    = 3'd2;
    localparam logic [RSEL_W-1:0] REG_STAGE_TWO    = 3'd3;
    localparam logic [RSEL_W-1:0] REG_STAGE_THREE  = 3'd4;
    localparam logic [RSEL_W-1:0] REG_FEATHER      = 3'd5;

    // command kinds and result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // datapath phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_RD0  = 3'd1;
    localparam logic [2:0] PH_RD1  = 3'd2;
    localparam logic [2:0] PH_WR   = 3'd3;
    localparam logic [2:0] PH_HWR  = 3'd4;
    localparam logic [2:0] PH_HRD  = 3'd5;

    // datapath element operations
    localparam logic [1:0] OP_COPY  = 2'd0;  // m2 = m1
    localparam logic [1:0] OP_PICK2 = 2'd1;  // m1 = pick(m1,nbr); m2 = pick(m2,m1)
    localparam logic [1:0] OP_PICK  = 2'd2;  // m1 = pick(m1,nbr)
    localparam logic [1:0] OP_AVG   = 2'd3;  // m1 = avg(m1,nbr)

    typedef struct packed {
        logic [DIM_W-1:0]             frame_width;
        logic [DIM_W-1:0]             frame_height;
        logic [2:0][PROG_W-1:0]       stage_prog;
        logic [PASS_W-1:0]            feather_passes;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        frame_width:    9'd256,
        frame_height:   9'd256,
        stage_prog:     '0,
        feather_passes: '0
    };

    typedef struct packed {
        logic [2:0] phase;
        logic       m1_b;   // primary operand lives in store b
        logic [1:0] op;
        logic       grow;
    } t_dp_cmd;

    function automatic logic [LEVEL_W-1:0] pick(input logic [LEVEL_W-1:0] a,
                                                input logic [LEVEL_W-1:0] b,
                                                input logic grow);
        if (grow) begin
            return (a < b) ? b : a;
        end
        return (a > b) ? b : a;
    endfunction

    function automatic logic [LEVEL_W-1:0] avg2(input logic [LEVEL_W-1:0] a,
                                                input logic [LEVEL_W-1:0] b);
        logic [LEVEL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEVEL_W:1];
    endfunction

    // op slot idx of a stage program; slots past the register read as growH
    function automatic logic [1:0] op_code(input logic [PROG_W-1:0] prog,
                                           input int unsigned idx);
        logic [31:0] t;
        t = 32'(prog) >> (4 + 2 * idx);
        return t[1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/mgsf_regs.sv
// Configuration register file behind the APB-style port.
// Depends on mgsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgsf_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mgsf_pkg::ADDR_W-1:0]  paddr,
    input  logic [mgsf_pkg::DATA_W-1:0]  pwdata,
    output logic [mgsf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output mgsf_pkg::t_cfg               o_cfg
);
    import mgsf_pkg::*;

    t_cfg              r_cfg;
    logic [RSEL_W-1:0] reg_sel;
    logic              wr_en;

    assign reg_sel = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_FRAME_WIDTH:  r_cfg.frame_width    <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height   <= pwdata[DIM_W-1:0];
                REG_STAGE_ONE:    r_cfg.stage_prog[0]  <= pwdata[PROG_W-1:0];
                REG_STAGE_TWO:    r_cfg.stage_prog[1]  <= pwdata[PROG_W-1:0];
                REG_STAGE_THREE:  r_cfg.stage_prog[2]  <= pwdata[PROG_W-1:0];
                REG_FEATHER:      r_cfg.feather_passes <= pwdata[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = DATA_W'(r_cfg.frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_cfg.frame_height);
            REG_STAGE_ONE:    prdata = DATA_W'(r_cfg.stage_prog[0]);
            REG_STAGE_TWO:    prdata = DATA_W'(r_cfg.stage_prog[1]);
            REG_STAGE_THREE:  prdata = DATA_W'(r_cfg.stage_prog[2]);
            REG_FEATHER:      prdata = DATA_W'(r_cfg.feather_passes);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/mgsf_dp.sv
// Datapath: the two frame stores, operand registers and the max/min/average unit.
// Depends on mgsf_pkg; driven by mgsf_ctrl through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module mgsf_dp #(
    parameter  int unsigned MAX_WIDTH  = mgsf_pkg::DEF_MAX_WIDTH,
    parameter  int unsigned MAX_HEIGHT = mgsf_pkg::DEF_MAX_HEIGHT,
    localparam int unsigned DEPTH      = MAX_WIDTH * MAX_HEIGHT,
    localparam int          AW         = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  mgsf_pkg::t_dp_cmd             i_cmd,
    input  logic [AW-1:0]                 i_cur,
    input  logic [AW-1:0]                 i_nbr,
    input  logic [mgsf_pkg::LEVEL_W-1:0]  i_wdata,
    output logic [mgsf_pkg::LEVEL_W-1:0]  o_rd_data
);
    import mgsf_pkg::*;

    logic [LEVEL_W-1:0] r_store_a [DEPTH];
    logic [LEVEL_W-1:0] r_store_b [DEPTH];
    logic [LEVEL_W-1:0] r_q_a, r_q_b;
    logic               r_qsel;
    logic [LEVEL_W-1:0] r_opa, r_opc;

    logic [AW-1:0]      m1_raddr, a_raddr, b_raddr;
    logic [LEVEL_W-1:0] m1_q, m2_q, val, m1_wd, m2_wd, a_wd, b_wd;
    logic               is_wr, m1_we, m2_we, a_we, b_we;

    // primary operand reads the element, then its neighbour
    assign m1_raddr = (i_cmd.phase == PH_RD1) ? i_nbr : i_cur;
    assign a_raddr  = i_cmd.m1_b ? i_cur : m1_raddr;
    assign b_raddr  = i_cmd.m1_b ? m1_raddr : i_cur;

    assign m1_q = r_qsel ? r_q_b : r_q_a;
    assign m2_q = r_qsel ? r_q_a : r_q_b;
    assign o_rd_data = m1_q;

    assign val   = (i_cmd.op == OP_AVG) ? avg2(r_opa, m1_q) : pick(r_opa, m1_q, i_cmd.grow);
    assign is_wr = (i_cmd.phase == PH_WR);
    assign m1_we = is_wr & (i_cmd.op != OP_COPY);
    assign m2_we = is_wr & ((i_cmd.op == OP_COPY) | (i_cmd.op == OP_PICK2));
    assign m1_wd = val;
    assign m2_wd = (i_cmd.op == OP_COPY) ? r_opa : pick(r_opc, val, i_cmd.grow);

    assign a_we = (i_cmd.phase == PH_HWR) | (i_cmd.m1_b ? m2_we : m1_we);
    assign a_wd = (i_cmd.phase == PH_HWR) ? i_wdata : (i_cmd.m1_b ? m2_wd : m1_wd);
    assign b_we = i_cmd.m1_b ? m1_we : m2_we;
    assign b_wd = i_cmd.m1_b ? m1_wd : m2_wd;

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_store_a[i_cur] <= a_wd;
        end
        r_q_a <= r_store_a[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_store_b[i_cur] <= b_wd;
        end
        r_q_b <= r_store_b[b_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_qsel <= i_cmd.m1_b;
        if (i_cmd.phase == PH_RD1) begin
            r_opa <= m1_q;
            r_opc <= m2_q;
        end
    end

endmodule

`default_nettype wire

FILE: src/mgsf_ctrl.sv
// Controller: command decode, stage/op/feather sequencing and the frame walk counters.
// Depends on mgsf_pkg; issues t_dp_cmd and addresses to mgsf_dp.
`timescale 1ns / 1ps
`default_nettype none

module mgsf_ctrl #(
    parameter  int unsigned MAX_WIDTH  = mgsf_pkg::DEF_MAX_WIDTH,
    parameter  int unsigned MAX_HEIGHT = mgsf_pkg::DEF_MAX_HEIGHT,
    parameter  int unsigned MAX_OPS    = mgsf_pkg::DEF_MAX_OPS,
    localparam int unsigned DEPTH      = MAX_WIDTH * MAX_HEIGHT,
    localparam int          AW         = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mgsf_pkg::t_cfg                i_cfg,
    input  logic                          i_start,
    input  logic [mgsf_pkg::KIND_W-1:0]   i_kind,
    input  logic [mgsf_pkg::INDEX_W-1:0]  i_pixel_index,
    output logic                          o_busy,
    output mgsf_pkg::t_dp_cmd             o_cmd,
    output logic [AW-1:0]                 o_cur,
    output logic [AW-1:0]                 o_nbr,
    output logic                          o_valid,
    output logic                          o_result_kind,
    output logic                          o_rd_zero
);
    import mgsf_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int OW = $clog2(MAX_OPS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PLAN = 3'd1;
    localparam logic [2:0] ST_NEXT = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_RD0  = 3'd4;
    localparam logic [2:0] ST_RD1  = 3'd5;
    localparam logic [2:0] ST_WR   = 3'd6;

    localparam logic [2:0] TK_COPY = 3'd0;
    localparam logic [2:0] TK_H    = 3'd1;
    localparam logic [2:0] TK_V    = 3'd2;
    localparam logic [2:0] TK_FH   = 3'd3;
    localparam logic [2:0] TK_FV   = 3'd4;

    localparam logic [1:0] LAST_STAGE = 2'd3;

    logic [2:0]      r_state, n_state;
    logic [2:0]      r_task, n_task;
    logic [1:0]      r_stage, n_stage;
    logic [OW-1:0]   r_opi, n_opi;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic            r_cur_b, n_cur_b;
    logic            r_grow, n_grow;
    logic            r_res_b, n_res_b;
    logic [XW-1:0]   r_x, n_x;
    logic [YW-1:0]   r_y, n_y;
    logic [AW-1:0]   r_base, n_base;
    logic            r_back, n_back;
    logic            r_valid, n_valid;
    logic            r_kind, n_kind;
    logic            r_zero, n_zero;

    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [XW-1:0]   w_last, w_pen;
    logic [YW-1:0]   h_last, h_pen;
    logic [AW-1:0]   w_a, cur_run, host_addr;
    logic [PROG_W-1:0] prog_cur;
    logic [3:0]      cnt_raw;
    logic [OW-1:0]   n_ops;
    logic [1:0]      code_next;
    logic            in_range, is_h, is_v, is_copy, sweep_end, pass_more;

    // frame size: zero acts as one, large values saturate
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(i_cfg.frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(i_cfg.frame_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(i_cfg.frame_height);
        end
    end

    assign w_last = XW'(w_eff - WW'(1));
    assign w_pen  = XW'(w_eff - WW'(2));
    assign h_last = YW'(h_eff - HW'(1));
    assign h_pen  = YW'(h_eff - HW'(2));
    assign w_a    = AW'(w_eff);

    always_comb begin
        case (r_stage)
            2'd0:    prog_cur = i_cfg.stage_prog[0];
            2'd1:    prog_cur = i_cfg.stage_prog[1];
            default: prog_cur = i_cfg.stage_prog[2];
        endcase
    end

    assign cnt_raw   = prog_cur[3:0];
    assign n_ops     = (32'(cnt_raw) > MAX_OPS) ? OW'(MAX_OPS) : OW'(cnt_raw);
    assign code_next = op_code(prog_cur, 32'(r_opi));
    assign pass_more = ({1'b0, r_pass} + 9'd1) < {1'b0, i_cfg.feather_passes};

    assign in_range  = 32'(i_pixel_index) < DEPTH;
    assign host_addr = AW'(32'(i_pixel_index));

    assign is_h    = (r_task == TK_H) | (r_task == TK_FH);
    assign is_v    = (r_task == TK_V) | (r_task == TK_FV);
    assign is_copy = (r_task == TK_COPY);

    assign cur_run = r_base + AW'(r_x);

    always_comb begin
        if (r_state == ST_IDLE) begin
            o_cur = host_addr;
            o_nbr = host_addr;
        end else begin
            o_cur = cur_run;
            if (is_h) begin
                o_nbr = r_back ? cur_run - AW'(1) : cur_run + AW'(1);
            end else if (is_v) begin
                o_nbr = r_back ? cur_run - w_a : cur_run + w_a;
            end else begin
                o_nbr = cur_run;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_task    = r_task;
        n_stage   = r_stage;
        n_opi     = r_opi;
        n_pass    = r_pass;
        n_cur_b   = r_cur_b;
        n_grow    = r_grow;
        n_res_b   = r_res_b;
        n_x       = r_x;
        n_y       = r_y;
        n_base    = r_base;
        n_back    = r_back;
        n_valid   = 1'b0;
        n_kind    = r_kind;
        n_zero    = r_zero;
        sweep_end = 1'b0;

        o_cmd.phase = PH_IDLE;
        o_cmd.m1_b  = (r_task == TK_V) ? ~r_cur_b : r_cur_b;
        o_cmd.grow  = r_grow;
        case (r_task)
            TK_COPY: o_cmd.op = OP_COPY;
            TK_H:    o_cmd.op = OP_PICK2;
            TK_V:    o_cmd.op = OP_PICK;
            default: o_cmd.op = OP_AVG;
        endcase

        case (r_state)
            ST_IDLE: begin
                o_cmd.m1_b = 1'b0;
                if (i_start) begin
                    case (i_kind)
                        KIND_WRITE: begin
                            if (in_range) begin
                                o_cmd.phase = PH_HWR;
                            end
                        end
                        KIND_READ: begin
                            o_cmd.phase = PH_HRD;
                            o_cmd.m1_b  = r_res_b;
                            n_valid     = 1'b1;
                            n_kind      = RES_READ;
                            n_zero      = ~in_range;
                        end
                        KIND_RUN: begin
                            n_stage = '0;
                            n_cur_b = 1'b0;
                            n_state = ST_PLAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PLAN: begin
                if (r_stage == LAST_STAGE) begin
                    if (i_cfg.feather_passes == '0) begin
                        n_res_b = r_cur_b;
                        n_valid = 1'b1;
                        n_kind  = RES_DONE;
                        n_zero  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_pass  = '0;
                        n_task  = TK_FH;
                        n_state = ST_LOAD;
                    end
                end else if (n_ops == '0) begin
                    n_stage = r_stage + 2'd1;
                end else begin
                    n_task  = TK_COPY;
                    n_opi   = '0;
                    n_state = ST_LOAD;
                end
            end
            ST_NEXT: begin
                case (r_task)
                    TK_FH: begin
                        n_state = ST_LOAD;
                        if (pass_more) begin
                            n_pass = r_pass + PASS_W'(1);
                        end else begin
                            n_pass = '0;
                            n_task = TK_FV;
                        end
                    end
                    TK_FV: begin
                        if (pass_more) begin
                            n_pass  = r_pass + PASS_W'(1);
                            n_state = ST_LOAD;
                        end else begin
                            n_res_b = r_cur_b;
                            n_valid = 1'b1;
                            n_kind  = RES_DONE;
                            n_zero  = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        if (r_opi < n_ops) begin
                            n_opi   = r_opi + OW'(1);
                            n_task  = code_next[0] ? TK_V : TK_H;
                            n_grow  = ~code_next[1];
                            n_state = ST_LOAD;
                        end else begin
                            n_cur_b = ~r_cur_b;
                            n_stage = r_stage + 2'd1;
                            n_state = ST_PLAN;
                        end
                    end
                endcase
            end
            ST_LOAD: begin
                n_x    = '0;
                n_y    = '0;
                n_base = '0;
                n_back = 1'b0;
                if ((is_h && w_eff == WW'(1)) || (is_v && h_eff == HW'(1))) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_RD0;
                end
            end
            ST_RD0: begin
                o_cmd.phase = PH_RD0;
                n_state     = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.phase = PH_RD1;
                n_state     = ST_WR;
            end
            ST_WR: begin
                o_cmd.phase = PH_WR;
                if (is_copy) begin
                    if (r_x == w_last) begin
                        n_x = '0;
                        if (r_y == h_last) begin
                            sweep_end = 1'b1;
                        end else begin
                            n_y    = r_y + YW'(1);
                            n_base = r_base + w_a;
                        end
                    end else begin
                        n_x = r_x + XW'(1);
                    end
                end else if (is_h) begin
                    if (!r_back) begin
                        if (r_x == w_pen) begin
                            n_back = 1'b1;
                            n_x    = w_last;
                        end else begin
                            n_x = r_x + XW'(1);
                        end
                    end else if (r_x == XW'(1)) begin
                        n_back = 1'b0;
                        n_x    = '0;
                        if (r_y == h_last) begin
                            sweep_end = 1'b1;
                        end else begin
                            n_y    = r_y + YW'(1);
                            n_base = r_base + w_a;
                        end
                    end else begin
                        n_x = r_x - XW'(1);
                    end
                end else begin
                    if (r_x == w_last) begin
                        n_x = '0;
                        if (!r_back) begin
                            // last forward row pair turns the walk around on row h-1
                            if (r_y == h_pen) begin
                                n_back = 1'b1;
                            end
                            n_y    = r_y + YW'(1);
                            n_base = r_base + w_a;
                        end else if (r_y == YW'(1)) begin
                            sweep_end = 1'b1;
                        end else begin
                            n_y    = r_y - YW'(1);
                            n_base = r_base - w_a;
                        end
                    end else begin
                        n_x = r_x + XW'(1);
                    end
                end
                n_state = sweep_end ? ST_NEXT : ST_RD0;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_task  <= TK_COPY;
            r_stage <= '0;
            r_opi   <= '0;
            r_pass  <= '0;
            r_cur_b <= 1'b0;
            r_grow  <= 1'b0;
            r_res_b <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_base  <= '0;
            r_back  <= 1'b0;
            r_valid <= 1'b0;
            r_kind  <= RES_READ;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_task  <= n_task;
            r_stage <= n_stage;
            r_opi   <= n_opi;
            r_pass  <= n_pass;
            r_cur_b <= n_cur_b;
            r_grow  <= n_grow;
            r_res_b <= n_res_b;
            r_x     <= n_x;
            r_y     <= n_y;
            r_base  <= n_base;
            r_back  <= n_back;
            r_valid <= n_valid;
            r_kind  <= n_kind;
            r_zero  <= n_zero;
        end
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_result_kind = r_kind;
    assign o_rd_zero     = r_zero;

endmodule

`default_nettype wire

FILE: src/mask_grow_shrink_feather.sv
// Top level of the mask grow/shrink/feather block: register file, controller, datapath.
// Depends on mgsf_pkg, mgsf_regs, mgsf_ctrl and mgsf_dp.
//
// Channel    Direction  Signals                                   Transfer
// command    in         start, busy, i_kind, i_pixel_index,       start high, busy low
//                       i_mask_value
// result     out        o_valid, o_result_kind, o_result_value    o_valid high, one cycle
// config     in/out     psel, penable, pwrite, paddr, pwdata,     psel & penable & pready
//                       prdata, pready
//
// Pixel writes and reads may follow back to back; read data appears in the cycle after
// the read transfer. A run walks the frame through one shared read-modify-write unit
// that reads the element, reads its neighbour and writes back, for each element visited:
// copy w*h, H op 2*h*(w-1), V op 2*w*(h-1), each feather pass 2*h*(w-1) + 2*w*(h-1);
// the done transfer comes in the first cycle busy is low again. Reset is synchronous and
// clears control state and registers; the frame stores are not cleared. The receiver
// cannot stall results, so nothing queues on the output.
`timescale 1ns / 1ps
`default_nettype none

module mask_grow_shrink_feather #(
    parameter  int unsigned MAX_WIDTH  = mgsf_pkg::DEF_MAX_WIDTH,
    parameter  int unsigned MAX_HEIGHT = mgsf_pkg::DEF_MAX_HEIGHT,
    parameter  int unsigned MAX_OPS    = mgsf_pkg::DEF_MAX_OPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [mgsf_pkg::KIND_W-1:0]   i_kind,
    input  logic [mgsf_pkg::INDEX_W-1:0]  i_pixel_index,
    input  logic [mgsf_pkg::LEVEL_W-1:0]  i_mask_value,
    // result channel
    output logic                          o_valid,
    output logic                          o_result_kind,
    output logic [mgsf_pkg::LEVEL_W-1:0]  o_result_value,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mgsf_pkg::ADDR_W-1:0]   paddr,
    input  logic [mgsf_pkg::DATA_W-1:0]   pwdata,
    output logic [mgsf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import mgsf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    t_cfg               cfg;
    t_dp_cmd            dp_cmd;
    logic [AW-1:0]      dp_cur, dp_nbr;
    logic [LEVEL_W-1:0] dp_rd_data;
    logic               rd_zero;

    mgsf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mgsf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_OPS    (MAX_OPS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_start       (start),
        .i_kind        (i_kind),
        .i_pixel_index (i_pixel_index),
        .o_busy        (busy),
        .o_cmd         (dp_cmd),
        .o_cur         (dp_cur),
        .o_nbr         (dp_nbr),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_rd_zero     (rd_zero)
    );

    mgsf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (dp_cmd),
        .i_cur     (dp_cur),
        .i_nbr     (dp_nbr),
        .i_wdata   (i_mask_value),
        .o_rd_data (dp_rd_data)
    );

    // done and out-of-range reads carry a zero level
    assign o_result_value = rd_zero ? '0 : dp_rd_data;

endmodule

`default_nettype wire

FILE: src/mgsf_checker.sv
// Port-level checker for the mask grow/shrink/feather block, bound to the top level.
// Depends on mgsf_pkg and mask_grow_shrink_feather.
`timescale 1ns / 1ps
`default_nettype none

module mgsf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [mgsf_pkg::KIND_W-1:0]   i_kind,
    input logic                          o_valid,
    input logic                          o_result_kind,
    input logic [mgsf_pkg::LEVEL_W-1:0]  o_result_value,
    input logic                          pready
);
    import mgsf_pkg::*;

    logic accept;
    assign accept = start & ~busy;

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_READ) |=> (o_valid && o_result_kind == RES_READ))
        else $error("read transfer without read result next cycle");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_WRITE) |=> !o_valid)
        else $error("write transfer produced a result");

    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_result_kind == RES_DONE && o_result_value == '0))
        else $error("run ended without a done result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == RES_DONE) |-> (!busy && $past(busy)))
        else $error("done result outside end of run");

endmodule

bind mask_grow_shrink_feather mgsf_checker u_mgsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_kind         (i_kind),
    .o_valid        (o_valid),
    .o_result_kind  (o_result_kind),
    .o_result_value (o_result_value),
    .pready         (pready)
);

`default_nettype wire
